>>> rtl/core/phw_pkg.sv
// ----------------------------------------------------------------------------
// phw_pkg
// Shared widths, register indexes, state types and helpers of the peak-hold
// bar meter.
// ----------------------------------------------------------------------------
`default_nettype none

package phw_pkg;

   localparam int MAX_CHANNELS_DEF = 8;

   localparam int SAMPLE_W   = 32;
   localparam int CHANNEL_W  = 3;
   localparam int POSITION_W = 32;
   localparam int BAR_W      = 12;

   localparam int ZOOM_W = 16;
   localparam int BITS_W = 6;
   localparam int HW_W   = 11;
   localparam int SEL_W  = 4;
   localparam int FILL_W = 16;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ZOOM        = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_BITS = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_WIDTH  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAN_SELECT = 8'd3;

   localparam logic [ZOOM_W-1:0] ZOOM_RESET = 16'd1;
   localparam logic [BITS_W-1:0] BITS_RESET = 6'd16;
   localparam logic [HW_W-1:0]   HW_RESET   = 11'd34;
   localparam logic [SEL_W-1:0]  SEL_RESET  = 4'd0;

   localparam logic [BITS_W-1:0] BITS_MIN  = 6'd8;
   localparam logic [BITS_W-1:0] BITS_MAX  = 6'd32;
   localparam logic [HW_W-1:0]   BAR_LIMIT = 11'd1024;

   // Divider datapath: product of magnitude and half width, then the
   // rounded numerator 2*prod + den.
   localparam int PROD_W = SAMPLE_W + HW_W;
   localparam int REM_W  = PROD_W + 2;
   localparam int QUOT_W = 12;
   localparam int QCNT_W = $clog2(QUOT_W);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_OUT
   } ctl_state_type;

   typedef enum logic [2:0] {
      DV_IDLE,
      DV_MUL,
      DV_LOAD,
      DV_RANGE,
      DV_ITER,
      DV_DONE
   } div_state_type;

   typedef struct packed {
      logic                start;
      logic [SAMPLE_W-1:0] peak;
      logic [BITS_W-1:0]   bits;
      logic [HW_W-1:0]     half_width;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [BAR_W-1:0] bar;
   } div_rsp_type;

   // Magnitude of a two's complement sample; the most negative value maps
   // to 2^31 as an unsigned number.
   function automatic logic [SAMPLE_W-1:0] magnitude(input logic [SAMPLE_W-1:0] v);
      magnitude = v[SAMPLE_W-1] ? (SAMPLE_W'(0) - v) : v;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/phw_ifs.sv
// ----------------------------------------------------------------------------
// phw_ifs
// Valid/ready channels of the peak-hold bar meter: sample input, bar output
// and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface phw_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [phw_pkg::SAMPLE_W-1:0]  sample;
   logic [phw_pkg::CHANNEL_W-1:0]        channel;
   logic                                 frame_end;
   logic                                 stream_end;

   modport source (output valid, sample, channel, frame_end, stream_end, input ready);
   modport sink   (input valid, sample, channel, frame_end, stream_end, output ready);
endinterface

interface phw_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [phw_pkg::POSITION_W-1:0]       position;
   logic [phw_pkg::CHANNEL_W-1:0]        out_channel;
   logic signed [phw_pkg::BAR_W-1:0]     bar;
   logic                                 row_end;

   modport source (output valid, position, out_channel, bar, row_end, input ready);
   modport sink   (input valid, position, out_channel, bar, row_end, output ready);
endinterface

interface phw_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [phw_pkg::CSR_INDEX_W-1:0]      index;
   logic [phw_pkg::CSR_DATA_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/phw_ram.sv
// ----------------------------------------------------------------------------
// phw_ram
// Generic single-clock RAM, one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module phw_ram #(
   parameter int WIDTH = phw_pkg::SAMPLE_W,
   parameter int DEPTH = phw_pkg::MAX_CHANNELS_DEF,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/phw_div.sv
// ----------------------------------------------------------------------------
// phw_div
// Bar length unit: scales a peak by the half width and divides by twice the
// full scale with rounding, one quotient bit per cycle, then saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module phw_div (
   input  logic                 clock,
   input  logic                 reset,
   input  phw_pkg::div_req_type div_req,
   output phw_pkg::div_rsp_type div_rsp
);
   import phw_pkg::*;

   div_state_type       state_ff, state_in;
   logic [SAMPLE_W-1:0] mag_ff;
   logic                neg_ff;
   logic [HW_W-1:0]     hw_ff;
   logic [SAMPLE_W-1:0] den_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [REM_W-1:0]    rem_ff;
   logic [REM_W-1:0]    sh_ff;
   logic [QUOT_W-1:0]   quot_ff;
   logic [QCNT_W-1:0]   cnt_ff;

   logic [BITS_W-1:0]   bits_c;
   logic [HW_W-1:0]     hw_c;
   logic [SAMPLE_W-1:0] scale_c;
   logic [SAMPLE_W-1:0] dsr_c;
   logic                fits_c;
   logic [QUOT_W-1:0]   qsat_c;

   always_comb begin
      if (div_req.bits < BITS_MIN) begin
         bits_c = BITS_MIN;
      end else if (div_req.bits > BITS_MAX) begin
         bits_c = BITS_MAX;
      end else begin
         bits_c = div_req.bits;
      end
      hw_c    = (div_req.half_width > BAR_LIMIT) ? BAR_LIMIT : div_req.half_width;
      scale_c = SAMPLE_W'(1) << (bits_c - BITS_W'(1));
      // den is at most 2^31 - 1, so twice it still fits the sample width.
      dsr_c   = {den_ff[SAMPLE_W-2:0], 1'b0};
      fits_c  = rem_ff >= sh_ff;
      qsat_c  = (quot_ff > QUOT_W'(hw_ff)) ? QUOT_W'(hw_ff) : quot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DV_IDLE:  if (div_req.start) state_in = DV_MUL;
         DV_MUL:   state_in = DV_LOAD;
         DV_LOAD:  state_in = DV_RANGE;
         DV_RANGE: state_in = fits_c ? DV_DONE : DV_ITER;
         DV_ITER:  if (cnt_ff == '0) state_in = DV_DONE;
         DV_DONE:  state_in = DV_IDLE;
         default:  state_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         DV_IDLE: begin
            if (div_req.start) begin
               mag_ff <= magnitude(div_req.peak);
               neg_ff <= div_req.peak[SAMPLE_W-1];
               hw_ff  <= hw_c;
               den_ff <= scale_c - SAMPLE_W'(1);
            end
         end
         DV_MUL: begin
            prod_ff <= PROD_W'(mag_ff) * PROD_W'(hw_ff);
         end
         DV_LOAD: begin
            rem_ff <= REM_W'({prod_ff, 1'b0}) + REM_W'(den_ff);
            // First compare checks for a quotient of 2^QUOT_W or more.
            sh_ff  <= REM_W'(dsr_c) << QUOT_W;
         end
         DV_RANGE: begin
            quot_ff <= fits_c ? '1 : '0;
            sh_ff   <= sh_ff >> 1;
            cnt_ff  <= QCNT_W'(QUOT_W - 1);
         end
         DV_ITER: begin
            if (fits_c) begin
               rem_ff <= rem_ff - sh_ff;
            end
            quot_ff <= {quot_ff[QUOT_W-2:0], fits_c};
            sh_ff   <= sh_ff >> 1;
            cnt_ff  <= cnt_ff - QCNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   assign div_rsp.done = (state_ff == DV_DONE);
   assign div_rsp.bar  = neg_ff ? (BAR_W'(0) - BAR_W'(qsat_c)) : BAR_W'(qsat_c);

endmodule

`default_nettype wire

>>> rtl/core/peak_hold_waveform_bars.sv
// Bar without emit: the item is read when it is accepted and written back in
// the following cycle; the next item can be taken once the write-back is done.
// Bar emitted: the item passes the divider's multiply, load and range states,
// its one-bit-per-cycle loop (skipped when the quotient saturates) and its done
// state, then waits until the output register is free. One item is in flight
// at a time; a waiting result blocks the input only when the next item also
// emits a bar. Reset restores the register defaults; the peak store reads as
// zero through per-channel valid bits, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
// peak_hold_waveform_bars
// Peak-hold bar meter: keeps the largest-magnitude sample of each channel
// over a group of frames and emits one scaled bar per shown channel.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_hold_waveform_bars #(
   parameter int MAX_CHANNELS = phw_pkg::MAX_CHANNELS_DEF
) (
   input logic        clock,
   input logic        reset,
   phw_req_if.sink    req_bus,
   phw_rsp_if.source  rsp_bus,
   phw_csr_if.sink    csr_bus
);
   import phw_pkg::*;

   localparam int ADDR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam logic [5:0] CH_COUNT = 6'(MAX_CHANNELS);

   // Configuration registers.
   logic [ZOOM_W-1:0] zoom_ff;
   logic [BITS_W-1:0] bits_ff;
   logic [HW_W-1:0]   hw_ff;
   logic [SEL_W-1:0]  sel_ff;

   // Frame counting.
   logic [POSITION_W-1:0] frame_ff;
   logic [FILL_W-1:0]     fill_ff;
   logic [POSITION_W-1:0] start_ff;

   // Item in flight.
   logic [SAMPLE_W-1:0]   smp_ff;
   logic [CHANNEL_W-1:0]  ch_ff;
   logic                  fend_ff;
   logic                  last_ff;
   logic                  present_ff;
   logic [POSITION_W-1:0] pos_ff;
   logic                  row_ff;
   logic [BAR_W-1:0]      hold_ff;

   // Output register.
   logic                  rsp_vld_ff;
   logic [POSITION_W-1:0] rsp_pos_ff;
   logic [CHANNEL_W-1:0]  rsp_ch_ff;
   logic [BAR_W-1:0]      rsp_bar_ff;
   logic                  rsp_row_ff;

   logic [MAX_CHANNELS-1:0] vld_ff;

   ctl_state_type state_ff, state_in;

   logic                req_fire;
   logic [ZOOM_W-1:0]   zoom_eff;
   logic                last_c;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W-1:0]   wr_addr;
   logic [SAMPLE_W-1:0] ram_rdata;
   logic [SAMPLE_W-1:0] old_pk;
   logic [SAMPLE_W-1:0] new_pk;
   logic                shown;
   logic                ram_we;
   logic                div_start;
   logic                hold_load;
   logic                out_load;
   logic [HW_W-1:0]     hw_lim;
   logic [BAR_W-1:0]    bar_mag;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;

   assign zoom_eff = (zoom_ff == '0) ? ZOOM_W'(1) : zoom_ff;
   assign last_c   = req_bus.stream_end
                     || ((17'(fill_ff) + 17'd1) >= 17'(zoom_eff));

   assign rd_addr = ADDR_W'(req_bus.channel);
   assign wr_addr = ADDR_W'(ch_ff);

   // A peak never written since reset reads as zero.
   assign old_pk = vld_ff[wr_addr] ? ram_rdata : '0;
   assign new_pk = (magnitude(smp_ff) >= magnitude(old_pk)) ? smp_ff : old_pk;
   assign shown  = (sel_ff == '0) || ((sel_ff - SEL_W'(1)) == SEL_W'(ch_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         zoom_ff <= ZOOM_RESET;
         bits_ff <= BITS_RESET;
         hw_ff   <= HW_RESET;
         sel_ff  <= SEL_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_ZOOM:        zoom_ff <= csr_bus.data[ZOOM_W-1:0];
            CSR_SAMPLE_BITS: bits_ff <= csr_bus.data[BITS_W-1:0];
            CSR_HALF_WIDTH:  hw_ff   <= csr_bus.data[HW_W-1:0];
            CSR_CHAN_SELECT: sel_ff  <= csr_bus.data[SEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Group bookkeeping depends only on the item's flags, so it is settled
   // when the item is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         fill_ff  <= '0;
         start_ff <= '0;
      end else if (req_fire && req_bus.frame_end) begin
         frame_ff <= frame_ff + POSITION_W'(1);
         if (last_c) begin
            fill_ff  <= '0;
            start_ff <= frame_ff + POSITION_W'(1);
         end else begin
            fill_ff  <= fill_ff + FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         smp_ff     <= req_bus.sample;
         ch_ff      <= req_bus.channel;
         fend_ff    <= req_bus.frame_end;
         last_ff    <= last_c;
         present_ff <= {3'b000, req_bus.channel} < CH_COUNT;
         pos_ff     <= start_ff;
      end
      if (state_ff == ST_READ) begin
         row_ff <= (sel_ff == '0) ? fend_ff : 1'b1;
      end
      if (hold_load) begin
         hold_ff <= div_rsp.bar;
      end
      if (out_load) begin
         rsp_pos_ff <= pos_ff;
         rsp_ch_ff  <= ch_ff;
         rsp_bar_ff <= hold_ff;
         rsp_row_ff <= row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ram_we) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The store is read only when an item is accepted and written back only
   // in the following cycle, so the same entry is never read and written at
   // once and no forwarding is needed.
   always_comb begin
      state_in  = state_ff;
      ram_we    = 1'b0;
      div_start = 1'b0;
      hold_load = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_READ;
         end
         ST_READ: begin
            ram_we = present_ff;
            if (present_ff && last_ff && shown) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in  = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               hold_load = 1'b1;
               state_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_vld_ff || rsp_bus.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   phw_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_CHANNELS)
   ) u_peak_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (last_ff ? '0 : new_pk),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   assign div_req.start      = div_start;
   assign div_req.peak       = new_pk;
   assign div_req.bits       = bits_ff;
   assign div_req.half_width = hw_ff;

   phw_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_bus.valid       = rsp_vld_ff;
   assign rsp_bus.position    = rsp_pos_ff;
   assign rsp_bus.out_channel = rsp_ch_ff;
   assign rsp_bus.bar         = rsp_bar_ff;
   assign rsp_bus.row_end     = rsp_row_ff;

   assign hw_lim  = (hw_ff > BAR_LIMIT) ? BAR_LIMIT : hw_ff;
   assign bar_mag = rsp_bar_ff[BAR_W-1] ? (BAR_W'(0) - rsp_bar_ff) : rsp_bar_ff;

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_bus.ready)
      else $error("input taken while an item is still in flight");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished with no bar pending");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && req_fire))
      else $error("peak store read and written in the same cycle");

   a_bar_range: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (bar_mag <= BAR_W'(hw_lim)))
      else $error("bar exceeds the half width");

endmodule

`default_nettype wire

>>> bench/phw_bar_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phw_bar_checker
// Watches the sample, bar and register channels of the peak-hold bar meter,
// keeps its own copy of the meter state, predicts every bar and compares the
// bars that come out, oldest first, field by field.
// ----------------------------------------------------------------------------
module phw_bar_checker (
   input  logic clock,
   input  logic reset,
   phw_req_if   req_mon,
   phw_rsp_if   rsp_mon,
   phw_csr_if   csr_mon,
   output int   fail_count,
   output int   pending,
   output int   items_seen,
   output int   bars_seen
);
   import phw_pkg::*;

   localparam int N_CH       = MAX_CHANNELS_DEF;
   localparam int MAX_PRINTS = 40;

   typedef struct packed {
      logic [POSITION_W-1:0] position;
      logic [CHANNEL_W-1:0]  channel;
      logic [BAR_W-1:0]      bar;
      logic                  row_end;
   } meter_bar_type;

   logic [ZOOM_W-1:0]   zoom_q;
   logic [BITS_W-1:0]   bits_q;
   logic [HW_W-1:0]     span_q;
   logic [SEL_W-1:0]    sel_q;
   logic [SAMPLE_W-1:0] peak_q [N_CH];
   logic [31:0]         frame_idx;
   logic [FILL_W-1:0]   fill_q;
   logic [31:0]         group_pos;
   meter_bar_type       bars_due[$];

   initial begin
      fail_count = 0;
      pending    = 0;
      items_seen = 0;
      bars_seen  = 0;
   end

   function automatic logic [31:0] magnitude_of(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   // Rounds half away from zero: (2*num + den) / (2*den), then saturates.
   function automatic logic [BAR_W-1:0] scaled_bar(input logic [31:0] pk);
      logic [5:0]  depth;
      logic [10:0] span;
      logic [63:0] den;
      logic [63:0] num;
      logic [63:0] q;
      depth = bits_q;
      if (depth < 6'd8) depth = 6'd8;
      if (depth > 6'd32) depth = 6'd32;
      span = span_q;
      if (span > 11'd1024) span = 11'd1024;
      den = (64'd1 << (depth - 6'd1)) - 64'd1;
      num = {32'd0, magnitude_of(pk)} * {53'd0, span};
      q = (64'd2 * num + den) / (64'd2 * den);
      if (q > {53'd0, span}) q = {53'd0, span};
      if (pk[31]) q = ~q + 64'd1;
      return q[BAR_W-1:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      if (fail_count <= MAX_PRINTS)
         $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      else if (fail_count == MAX_PRINTS + 1)
         $display("[%0t] further mismatches are counted but not printed", $time);
   endtask

   task automatic fold_sample(input logic [31:0] smp, input logic [2:0] ch,
                              input logic fe, input logic se);
      logic [31:0]   zoom_eff;
      logic          closes;
      meter_bar_type row;
      zoom_eff = (zoom_q == '0) ? 32'd1 : {16'd0, zoom_q};
      closes = se || ({16'd0, fill_q} + 32'd1 >= zoom_eff);
      // On equal magnitude the later sample takes over the peak.
      if (magnitude_of(smp) >= magnitude_of(peak_q[ch])) peak_q[ch] = smp;
      if (closes) begin
         if (sel_q == '0 || {1'b0, ch} == sel_q - 4'd1) begin
            row.position = group_pos;
            row.channel  = ch;
            row.bar      = scaled_bar(peak_q[ch]);
            row.row_end  = (sel_q == '0) ? fe : 1'b1;
            bars_due.push_back(row);
         end
         peak_q[ch] = '0;
      end
      if (fe) begin
         frame_idx = frame_idx + 32'd1;
         if (closes) begin
            fill_q    = '0;
            group_pos = frame_idx;
         end else begin
            fill_q = fill_q + 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin : track
      meter_bar_type row;
      if (reset) begin
         zoom_q    = ZOOM_RESET;
         bits_q    = BITS_RESET;
         span_q    = HW_RESET;
         sel_q     = SEL_RESET;
         frame_idx = '0;
         fill_q    = '0;
         group_pos = '0;
         for (int i = 0; i < N_CH; i++) peak_q[i] = '0;
         bars_due.delete();
      end else begin
         // Outputs are checked before the item of this edge is folded in, so a
         // stray bar can never be matched against the newest prediction.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (bars_due.size() == 0) begin
               report_mismatch("bar with nothing expected", rsp_mon.position, '0);
            end else begin
               row = bars_due.pop_front();
               bars_seen++;
               if (rsp_mon.position !== row.position)
                  report_mismatch("position", rsp_mon.position, row.position);
               if (rsp_mon.out_channel !== row.channel)
                  report_mismatch("out_channel", 32'(rsp_mon.out_channel), 32'(row.channel));
               if (rsp_mon.bar !== row.bar)
                  report_mismatch("bar", 32'(rsp_mon.bar), 32'(row.bar));
               if (rsp_mon.row_end !== row.row_end)
                  report_mismatch("row_end", 32'(rsp_mon.row_end), 32'(row.row_end));
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_ZOOM:        zoom_q = csr_mon.data[ZOOM_W-1:0];
               CSR_SAMPLE_BITS: bits_q = csr_mon.data[BITS_W-1:0];
               CSR_HALF_WIDTH:  span_q = csr_mon.data[HW_W-1:0];
               CSR_CHAN_SELECT: sel_q  = csr_mon.data[SEL_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            fold_sample(req_mon.sample, req_mon.channel, req_mon.frame_end,
                        req_mon.stream_end);
            items_seen++;
         end
      end
      pending = bars_due.size();
   end

endmodule

>>> bench/tb_peak_hold_waveform_bars.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_peak_hold_waveform_bars
// Drives multichannel sample streams and register settings into the peak-hold
// bar meter with random gaps and output stalls; the checker predicts and
// compares the bars, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_peak_hold_waveform_bars;
   import phw_pkg::*;

   localparam int ITEM_TARGET   = 900;
   localparam int MAX_GAP       = 12;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 400000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 8'd9;

   logic clock;
   logic reset;

   phw_req_if req_bus ();
   phw_rsp_if rsp_bus ();
   phw_csr_if csr_bus ();

   int chk_fails;
   int chk_pending;
   int chk_items;
   int chk_bars;

   int cycle_count = 0;
   int sent_items  = 0;
   int phases      = 0;
   int gap_mode    = 0;

   logic [BITS_W-1:0]   cur_bits;
   logic [ZOOM_W-1:0]   cur_zoom;
   logic [SAMPLE_W-1:0] last_sample [MAX_CHANNELS_DEF];

   peak_hold_waveform_bars u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   phw_bar_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_mon    (csr_bus),
      .fail_count (chk_fails),
      .pending    (chk_pending),
      .items_seen (chk_items),
      .bars_seen  (chk_bars)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("peak_hold_waveform_bars verification failed");
         $finish;
      end
   end

   function automatic int draw_gap();
      case (gap_mode)
         0: return 0;
         1: return $urandom_range(0, MAX_GAP);
         default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_GAP) : 0;
      endcase
   endfunction

   // Mixes full-range noise, extremes, exact ties of opposite sign and values
   // around the full scale of the current depth.
   function automatic logic [31:0] pick_sample(input logic [2:0] ch);
      logic [5:0]  depth;
      logic [31:0] full;
      logic [31:0] mag;
      logic [31:0] pick;
      depth = cur_bits;
      if (depth < 6'd8) depth = 6'd8;
      if (depth > 6'd32) depth = 6'd32;
      full = (32'd1 << (depth - 6'd1)) - 32'd1;
      case ($urandom_range(0, 9))
         0: pick = $urandom;
         1: begin
            case ($urandom_range(0, 4))
               0: pick = 32'h7FFF_FFFF;
               1: pick = 32'h8000_0000;
               2: pick = 32'h0000_0000;
               3: pick = 32'hFFFF_FFFF;
               default: pick = ~full + 32'd1;
            endcase
         end
         2: pick = ~last_sample[ch] + 32'd1;
         3: pick = full + 32'($urandom_range(0, 2)) - 32'd1;
         default: begin
            mag = $urandom_range(0, full);
            pick = $urandom_range(0, 1) ? (~mag + 32'd1) : mag;
         end
      endcase
      last_sample[ch] = pick;
      return pick;
   endfunction

   task automatic send_sample(input logic [31:0] smp, input logic [2:0] ch,
                              input logic fe, input logic se);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.sample     <= smp;
      req_bus.channel    <= ch;
      req_bus.frame_end  <= fe;
      req_bus.stream_end <= se;
      do @(posedge clock); while (!req_bus.ready);
      sent_items++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_meter(input logic [15:0] zoom, input logic [5:0] depth,
                            input logic [10:0] span, input logic [3:0] sel);
      write_reg(CSR_ZOOM, zoom);
      write_reg(CSR_SAMPLE_BITS, {10'd0, depth});
      write_reg(CSR_HALF_WIDTH, {5'd0, span});
      write_reg(CSR_CHAN_SELECT, {12'd0, sel});
      cur_zoom = zoom;
      cur_bits = depth;
      phases++;
   endtask

   // Items that close no group leave no bar behind, so SETTLE_CYCLES more
   // cover the write-back of the last one before registers change.
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (chk_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic play_stream(input int nch, input int nframes, input bit broken);
      logic [2:0] ch;
      logic       fe;
      logic       se;
      for (int f = 0; f < nframes; f++) begin
         for (int c = 0; c < nch; c++) begin
            ch = 3'(c);
            fe = (c == nch - 1);
            se = (f == nframes - 1);
            if (broken) begin
               if ($urandom_range(0, 3) == 0) ch = 3'($urandom_range(0, 7));
               if ($urandom_range(0, 5) == 0) fe = ~fe;
               if ($urandom_range(0, 5) == 0) se = ~se;
            end
            send_sample(pick_sample(ch), ch, fe, se);
         end
      end
   endtask

   // Result side: a random stall before each item, eager stretches, and two
   // long holds while the input keeps coming.
   initial begin : bar_sink
      int  stall;
      int  taken;
      bit  eager;
      taken = 0;
      eager = 1'b0;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (taken % 40 == 0) eager = ($urandom_range(0, 2) == 0);
         stall = eager ? 0 : $urandom_range(0, MAX_GAP);
         if (taken == 25 || taken == 250) stall = LONG_HOLD;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         taken++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int         nch;
      int         nfr;
      int         stop_at;
      logic [15:0] zoom;
      logic [5:0]  depth;
      logic [10:0] span;
      logic [3:0]  sel;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.sample     = '0;
      req_bus.channel    = '0;
      req_bus.frame_end  = 1'b0;
      req_bus.stream_end = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = '0;
      csr_bus.data       = '0;
      cur_zoom = ZOOM_RESET;
      cur_bits = BITS_RESET;
      for (int i = 0; i < MAX_CHANNELS_DEF; i++) last_sample[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: full scale both ways, saturation, most negative, zero.
      send_sample(32'h0000_7FFF, 3'd0, 1'b0, 1'b0);
      send_sample(32'hFFFF_8001, 3'd1, 1'b1, 1'b0);
      send_sample(32'h7FFF_FFFF, 3'd0, 1'b0, 1'b0);
      send_sample(32'h8000_0000, 3'd1, 1'b1, 1'b0);
      send_sample(32'h0000_0000, 3'd0, 1'b0, 1'b0);
      send_sample(32'hFFFF_FFFF, 3'd1, 1'b1, 1'b0);
      settle();

      // Groups of three: a tie where the later negative sample wins, a
      // repeated channel in the last frame, then a partial group at stream end.
      set_meter(16'd3, 6'd8, 11'd4, 4'd0);
      send_sample(32'd100, 3'd0, 1'b0, 1'b0);
      send_sample(-32'sd100, 3'd1, 1'b1, 1'b0);
      send_sample(-32'sd100, 3'd0, 1'b0, 1'b0);
      send_sample(32'd127, 3'd1, 1'b1, 1'b0);
      send_sample(32'd3, 3'd0, 1'b0, 1'b0);
      send_sample(-32'sd128, 3'd0, 1'b0, 1'b0);
      send_sample(32'd0, 3'd1, 1'b1, 1'b0);
      send_sample(32'd64, 3'd0, 1'b0, 1'b1);
      send_sample(-32'sd63, 3'd1, 1'b1, 1'b1);
      settle();

      // Zoom zero, depth and width beyond their limits, one channel shown.
      set_meter(16'd0, 6'd63, 11'd2047, 4'd2);
      send_sample(32'h0000_0001, 3'd0, 1'b0, 1'b0);
      send_sample(32'h4000_0000, 3'd1, 1'b0, 1'b0);
      send_sample(32'h1234_5678, 3'd2, 1'b1, 1'b0);
      send_sample(32'h8000_0001, 3'd0, 1'b0, 1'b0);
      send_sample(32'hC000_0000, 3'd1, 1'b0, 1'b0);
      send_sample(32'h7FFF_FFFF, 3'd2, 1'b1, 1'b0);
      settle();

      while (sent_items < ITEM_TARGET) begin
         case (phases)
            3: set_meter(16'd65535, 6'd32, 11'd1024, 4'd8);
            4: set_meter(16'd1, 6'd8, 11'd4, 4'd0);
            5: begin
               set_meter(16'd2, 6'd0, 11'd0, 4'd15);
               write_reg(CSR_UNUSED, 16'hFFFF);
            end
            default: begin
               case ($urandom_range(0, 9))
                  0: zoom = 16'd0;
                  1: zoom = 16'd65535;
                  2: zoom = 16'($urandom_range(1, 65535));
                  3: zoom = 16'd1;
                  default: zoom = 16'($urandom_range(1, 5));
               endcase
               case ($urandom_range(0, 7))
                  0: depth = 6'd8;
                  1: depth = 6'd32;
                  2: depth = 6'($urandom_range(0, 63));
                  3: depth = 6'd16;
                  default: depth = 6'($urandom_range(8, 32));
               endcase
               case ($urandom_range(0, 7))
                  0: span = 11'd0;
                  1: span = 11'd4;
                  2: span = 11'd1024;
                  3: span = 11'($urandom_range(1025, 2047));
                  default: span = 11'($urandom_range(4, 1024));
               endcase
               case ($urandom_range(0, 7))
                  0, 1, 2, 3: sel = 4'd0;
                  4: sel = 4'($urandom_range(9, 15));
                  default: sel = 4'($urandom_range(1, 8));
               endcase
               set_meter(zoom, depth, span, sel);
            end
         endcase
         gap_mode = $urandom_range(0, 2);
         stop_at = sent_items + $urandom_range(40, 110);
         while (sent_items < stop_at) begin
            nch = $urandom_range(1, 8);
            nfr = (cur_zoom == 0) ? 1 : 3 * int'(cur_zoom) + 1;
            if (nfr > 8) nfr = 8;
            nfr = $urandom_range(1, nfr);
            play_stream(nch, nfr, $urandom_range(0, 4) == 0);
         end
         settle();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Run covered %0d sample items under %0d register settings; %0d bars compared.",
               chk_items, phases, chk_bars);
      $display("Output holds of %0d cycles stalled the input while samples kept coming.",
               LONG_HOLD);
      if (chk_fails == 0) begin
         $display("peak_hold_waveform_bars verification clean");
      end else begin
         $display("peak_hold_waveform_bars verification failed");
      end
      $finish;
   end

endmodule
